>>> src/ifhg_pkg.sv
// Package: shared types and constants for the IPv4 fragment header generator.
`timescale 1ns / 1ps
`default_nettype none

package ifhg_pkg;

  localparam int unsigned MTU_W       = 14;
  localparam int unsigned TTL_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 14;

  localparam logic [MTU_W-1:0] MTU_RESET = 14'd1500;
  localparam logic [TTL_W-1:0] TTL_RESET = 8'd64;
  localparam logic [MTU_W-1:0] MIN_STEP  = 14'd1032;
  localparam logic [15:0]      VER_IHL_WORD = 16'h4500;
  localparam logic [15:0]      IP_HDR_BYTES = 16'd20;

  localparam logic [CFG_IDX_W-1:0] REG_MTU = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL = 2'd1;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol_number;
    logic [15:0] payload_bytes;
    logic [6:0]  overhead_bytes;
  } ifhg_in_t;

  typedef struct packed {
    logic [12:0] offset_units;
    logic        more_fragments;
    logic [15:0] fragment_payload;
    logic [15:0] ip_total_length;
    logic [16:0] frame_length;
    logic [15:0] ident_value;
    logic [15:0] hdr_csum;
    logic        last_of_packet;
  } ifhg_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FRAG,
    ST_FOLD
  } ifhg_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic frag;
    logic emit;
  } ifhg_cmd_t;

  typedef struct packed {
    logic frag_last;
    logic out_free;
  } ifhg_status_t;

endpackage

`default_nettype wire

>>> src/ifhg_ctrl.sv
// Controller: sequences packet setup, fragment build and checksum fold.
`timescale 1ns / 1ps
`default_nettype none

module ifhg_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  ifhg_pkg::ifhg_status_t status,
  output ifhg_pkg::ifhg_cmd_t    cmd
);
  import ifhg_pkg::*;

  ifhg_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_FRAG;
      ST_FRAG:  state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (status.out_free) state_nxt = status.frag_last ? ST_IDLE : ST_FRAG;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_FRAG:  cmd.frag  = 1'b1;
      ST_FOLD:  cmd.emit  = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/ifhg_datapath.sv
// Datapath: config registers, ident counter, fragment arithmetic and checksum.
`timescale 1ns / 1ps
`default_nettype none

module ifhg_datapath (
  input  wire                                clk,
  input  wire                                rst_n,
  input  ifhg_pkg::ifhg_in_t                 in_data,
  input  wire                                cfg_valid,
  input  wire [ifhg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [ifhg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ifhg_pkg::ifhg_cmd_t                cmd,
  output ifhg_pkg::ifhg_status_t             status,
  output logic                               out_valid,
  input  wire                                out_ready,
  output ifhg_pkg::ifhg_out_t                out_data
);
  import ifhg_pkg::*;

  logic [MTU_W-1:0] mtu_r;
  logic [TTL_W-1:0] ttl_r;
  logic [15:0]      ctr_r;

  ifhg_in_t         in_r;
  logic [15:0]      rem_r, off_r, ident_r;
  logic [MTU_W-1:0] step_r, limit_r;
  logic [18:0]      base_r;

  logic [15:0]      len_f_r, total_f_r;
  logic [12:0]      units_f_r;
  logic             last_f_r;
  logic [16:0]      frame_f_r;
  logic [19:0]      sum_f_r;

  logic             out_valid_r;
  ifhg_out_t        out_r;

  // setup arithmetic
  logic [16:0]      need;
  logic             fits;
  logic [MTU_W-1:0] room, step_raw, step, limit;
  logic [15:0]      ident_sel;
  logic [18:0]      base;

  // fragment arithmetic
  logic             last;
  logic [15:0]      len, total;
  logic [15:0]      flagoff;

  // fold
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign need = {10'd0, in_r.overhead_bytes} + {1'b0, in_r.payload_bytes};
  assign fits = need <= {3'd0, mtu_r};

  always_comb begin
    room     = (mtu_r > {7'd0, in_r.overhead_bytes}) ?
               (mtu_r - {7'd0, in_r.overhead_bytes}) : '0;
    step_raw = {room[MTU_W-1:3], 3'b000};
    step     = (step_raw < MIN_STEP) ? MIN_STEP : step_raw;
    limit    = fits ? '1 : ((room > step) ? room : step);
    ident_sel = fits ? 16'd0 : ctr_r;
    base     = {3'd0, VER_IHL_WORD}
             + {3'd0, ttl_r, in_r.protocol_number}
             + {3'd0, in_r.source_address[31:16]}
             + {3'd0, in_r.source_address[15:0]}
             + {3'd0, in_r.dest_address[31:16]}
             + {3'd0, in_r.dest_address[15:0]}
             + {3'd0, ident_sel};
  end

  always_comb begin
    last    = rem_r <= {2'd0, limit_r};
    len     = last ? rem_r : {2'd0, step_r};
    total   = len + IP_HDR_BYTES;
    flagoff = {2'b00, ~last, off_r[15:3]};
  end

  assign fold1 = {1'b0, sum_f_r[15:0]} + {13'd0, sum_f_r[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r <= MTU_RESET;
      ttl_r <= TTL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MTU) mtu_r <= cfg_data[MTU_W-1:0];
      if (cfg_index == REG_TTL) ttl_r <= cfg_data[TTL_W-1:0];
    end
  end

  // advance the identification counter only for packets that split
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (cmd.setup && !fits) begin
      ctr_r <= ctr_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.setup) begin
      rem_r   <= in_r.payload_bytes;
      off_r   <= '0;
      step_r  <= step;
      limit_r <= limit;
      ident_r <= ident_sel;
      base_r  <= base;
    end else if (cmd.frag && !last) begin
      rem_r <= rem_r - len;
      off_r <= off_r + len;
    end
    if (cmd.frag) begin
      len_f_r   <= len;
      total_f_r <= total;
      units_f_r <= off_r[15:3];
      last_f_r  <= last;
      frame_f_r <= {10'd0, in_r.overhead_bytes} + {1'b0, len};
      sum_f_r   <= {1'b0, base_r} + {4'd0, total} + {4'd0, flagoff};
    end
    if (cmd.emit) begin
      out_r.offset_units     <= units_f_r;
      out_r.more_fragments   <= ~last_f_r;
      out_r.fragment_payload <= len_f_r;
      out_r.ip_total_length  <= total_f_r;
      out_r.frame_length     <= frame_f_r;
      out_r.ident_value      <= ident_r;
      out_r.hdr_csum         <= ~fold2;
      out_r.last_of_packet   <= last_f_r;
    end
  end

  // hold the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.frag_last = last_f_r;
  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

`default_nettype wire

>>> src/ipv4_fragment_header_generator.sv
// Top level: IPv4 fragment header generator.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet descriptor word and returns one header word per fragment,
// or a single unfragmented header (identification 0) when the frame fits the
// MTU. A descriptor goes through one setup step after acceptance, then each
// fragment takes two steps (fragment build, then checksum fold into the output
// register); the fold waits while the output register holds a word not taken.
// Up to 64 fragments per packet. The output register lets the final word of a
// packet wait while the next descriptor is taken. Configuration (index 0: MTU,
// index 1: TTL) is to be written only while the block is idle; the block does
// not enforce this itself. Other indices are ignored.
module ipv4_fragment_header_generator (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  ifhg_pkg::ifhg_in_t              in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output ifhg_pkg::ifhg_out_t             out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [ifhg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ifhg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ifhg_pkg::*;

  ifhg_cmd_t    cmd;
  ifhg_status_t status;

  assign cfg_ready = 1'b1;

  ifhg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ifhg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> bench/ifhg_checker.sv
// Header checker: predicts fragment headers from accepted descriptors and compares.
`timescale 1ns / 1ps

module ifhg_header_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  input  wire                             in_ready,
  input  ifhg_pkg::ifhg_in_t              in_data,
  input  wire                             out_valid,
  input  wire                             out_ready,
  input  ifhg_pkg::ifhg_out_t             out_data,
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire [ifhg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [ifhg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              words_due
);
  import ifhg_pkg::*;

  localparam int unsigned MAX_FRAGMENTS = 64;

  logic [MTU_W-1:0] mtu_reg;
  logic [TTL_W-1:0] ttl_reg;
  logic [15:0]      ident_ctr;
  ifhg_out_t        hdr_due[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  function automatic logic [15:0] ip_checksum(ifhg_in_t pkt, logic [15:0] total,
                                              logic [15:0] ident, logic [15:0] flag_off);
    logic [31:0] acc;
    acc = {16'd0, VER_IHL_WORD} + {16'd0, total} + {16'd0, ident} + {16'd0, flag_off}
        + {16'd0, ttl_reg, pkt.protocol_number}
        + {16'd0, pkt.source_address[31:16]} + {16'd0, pkt.source_address[15:0]}
        + {16'd0, pkt.dest_address[31:16]} + {16'd0, pkt.dest_address[15:0]};
    while (acc[31:16] != 16'd0)
      acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  function automatic ifhg_out_t build_header(ifhg_in_t pkt, int unsigned off, logic mf,
                                             int unsigned len, logic [15:0] ident,
                                             logic last);
    ifhg_out_t h;
    h.offset_units     = 13'(off >> 3);
    h.more_fragments   = mf;
    h.fragment_payload = 16'(len);
    h.ip_total_length  = 16'(len + 20);
    h.frame_length     = 17'(32'(pkt.overhead_bytes) + len);
    h.ident_value      = ident;
    h.hdr_csum         = ip_checksum(pkt, h.ip_total_length, ident,
                                     {2'b00, mf, h.offset_units});
    h.last_of_packet   = last;
    return h;
  endfunction

  // Queue every header that one descriptor gives rise to.
  function automatic void predict_headers(ifhg_in_t pkt);
    int unsigned payload, ovh, room, step, left, off, len, n;
    logic [15:0] ident;
    logic        last;
    logic        done;
    payload = 32'(pkt.payload_bytes);
    ovh     = 32'(pkt.overhead_bytes);
    if (ovh + payload <= 32'(mtu_reg)) begin
      hdr_due.push_back(build_header(pkt, 0, 1'b0, payload, 16'd0, 1'b1));
    end else begin
      ident     = ident_ctr;
      ident_ctr = ident_ctr + 16'd1;
      room = (32'(mtu_reg) > ovh) ? (32'(mtu_reg) - ovh) : 0;
      step = room & ~32'd7;
      // keep the step large enough that no packet needs more than 64 fragments
      if (step < 32'(MIN_STEP))
        step = 32'(MIN_STEP);
      left = payload;
      off  = 0;
      n    = 0;
      done = 1'b0;
      while (!done && n < MAX_FRAGMENTS) begin
        last = (left <= room) || (left <= step);
        len  = last ? left : step;
        hdr_due.push_back(build_header(pkt, off, !last, len, ident, last));
        n++;
        done = last;
        left = left - len;
        off  = off + len;
      end
    end
  endfunction

  always @(posedge clk) begin
    ifhg_out_t want;
    if (!rst_n) begin
      mtu_reg   = MTU_RESET;
      ttl_reg   = TTL_RESET;
      ident_ctr = 16'd0;
      hdr_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MTU: mtu_reg = cfg_data;
          REG_TTL: ttl_reg = cfg_data[TTL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (hdr_due.size() == 0) begin
          report_mismatch("header word with none expected");
        end else begin
          want = hdr_due.pop_front();
          check_field("offset_units", 32'(out_data.offset_units),
                      32'(want.offset_units));
          check_field("more_fragments", 32'(out_data.more_fragments),
                      32'(want.more_fragments));
          check_field("fragment_payload", 32'(out_data.fragment_payload),
                      32'(want.fragment_payload));
          check_field("ip_total_length", 32'(out_data.ip_total_length),
                      32'(want.ip_total_length));
          check_field("frame_length", 32'(out_data.frame_length),
                      32'(want.frame_length));
          check_field("ident_value", 32'(out_data.ident_value),
                      32'(want.ident_value));
          check_field("hdr_csum", 32'(out_data.hdr_csum),
                      32'(want.hdr_csum));
          check_field("last_of_packet", 32'(out_data.last_of_packet),
                      32'(want.last_of_packet));
        end
      end
      if (in_valid && in_ready)
        predict_headers(in_data);
    end
    words_due = hdr_due.size();
  end

endmodule

>>> bench/ipv4_fragment_header_generator_tb.sv
// Testbench top: drives descriptors and configuration, gives the verdict.
`timescale 1ns / 1ps

module ipv4_fragment_header_generator_tb;
  import ifhg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned LONG_HOLD   = 300;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  ifhg_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ifhg_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int   mismatch_count;
  int   words_due;
  logic calm     = 1'b0;
  int   hold_req = 0;
  int   hold_len;

  always #5 clk = ~clk;

  ipv4_fragment_header_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ifhg_header_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_due      (words_due)
  );

  // Receiver: random back-pressure, with one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_len = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic ifhg_in_t make_desc(logic [31:0] src, logic [31:0] dst,
                                         logic [7:0] proto, logic [15:0] payload,
                                         logic [6:0] ovh);
    ifhg_in_t d;
    d.source_address  = src;
    d.dest_address    = dst;
    d.protocol_number = proto;
    d.payload_bytes   = payload;
    d.overhead_bytes  = ovh;
    return d;
  endfunction

  // Mostly modest payloads; a few reach the full 16-bit range.
  function automatic ifhg_in_t random_desc();
    int unsigned sel;
    logic [15:0] payload;
    logic [6:0]  ovh;
    sel = $urandom_range(99);
    if (sel < 50)
      payload = 16'($urandom_range(1600, 0));
    else if (sel < 75)
      payload = 16'($urandom_range(9000, 1600));
    else if (sel < 90)
      payload = 16'($urandom_range(30000, 9000));
    else
      payload = 16'($urandom_range(65535, 30000));
    ovh = ($urandom_range(99) < 88) ? 7'($urandom_range(64, 20))
                                    : 7'($urandom_range(127, 0));
    return make_desc($urandom, $urandom, 8'($urandom_range(255, 0)), payload, ovh);
  endfunction

  task automatic send_descriptor(input ifhg_in_t d);
    int gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop offering descriptors and wait for every header to come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic set_config(input logic [MTU_W-1:0] mtu, input logic [TTL_W-1:0] ttl,
                            input bit spare);
    if (spare) begin
      write_register(REG_SPARE_A, 14'($urandom));
      write_register(REG_SPARE_B, 14'($urandom));
    end
    write_register(REG_MTU, mtu);
    // upper data bits are junk for the TTL register
    write_register(REG_TTL, {6'($urandom), ttl});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: MTU 1500, TTL 64
    send_descriptor(make_desc(32'h0, 32'h0, 8'd0, 16'd0, 7'd20));
    send_descriptor(make_desc(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 16'd1480, 7'd20));
    send_descriptor(make_desc(32'hC0A8_0001, 32'h0A00_0001, 8'd17, 16'd1481, 7'd20));
    send_descriptor(make_desc(32'hC0A8_0002, 32'h0A00_0002, 8'd6, 16'd1480, 7'd64));
    send_descriptor(make_desc(32'h0102_0304, 32'h0506_0708, 8'd1, 16'd2948, 7'd22));
    send_descriptor(make_desc(32'hFFFF_0000, 32'h0000_FFFF, 8'd17, 16'd65515, 7'd20));
    send_descriptor(make_desc(32'h8000_0001, 32'h7FFF_FFFE, 8'd6, 16'd65535, 7'd127));
    send_descriptor(make_desc(32'h1234_5678, 32'h9ABC_DEF0, 8'd50, 16'd100, 7'd0));
    send_descriptor(make_desc(32'h5555_AAAA, 32'hAAAA_5555, 8'hAA, 16'h5555, 7'h2A));
    send_descriptor(make_desc(32'hDEAD_BEEF, 32'hCAFE_F00D, 8'd132, 16'd9000, 7'd64));
    drain();

    // MTU 1100, TTL 0: the step is raised to its floor
    set_config(14'd1100, 8'd0, 1'b1);
    send_descriptor(make_desc(32'hFFFF_FFFF, 32'h0, 8'd255, 16'd65535, 7'd127));
    send_descriptor(make_desc(32'h0, 32'hFFFF_FFFF, 8'd0, 16'd0, 7'd64));
    send_descriptor(make_desc(32'hA0B0_C0D0, 32'h1020_3040, 8'd17, 16'd1036, 7'd64));
    send_descriptor(make_desc(32'hA0B0_C0D1, 32'h1020_3041, 8'd17, 16'd1037, 7'd64));
    drain();

    // MTU 40, at or below the overhead of most descriptors: no room for those
    set_config(14'd40, 8'd255, 1'b0);
    send_descriptor(make_desc(32'h0A0B_0C0D, 32'h0E0F_1011, 8'd6, 16'd0, 7'd64));
    send_descriptor(make_desc(32'h0A0B_0C0E, 32'h0E0F_1012, 8'd6, 16'd5000, 7'd40));
    send_descriptor(make_desc(32'h0A0B_0C0F, 32'h0E0F_1013, 8'd6, 16'd20, 7'd20));
    send_descriptor(make_desc(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 16'd65535, 7'd64));
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(14'd1500, 8'($urandom_range(255, 0)), 1'b0);
        1: set_config(14'd9216, 8'd255, 1'b1);
        2: set_config(14'd1100, 8'd0, 1'b0);
        3: set_config(14'($urandom_range(9216, 1100)), 8'($urandom_range(255, 0)), 1'b0);
        4: set_config(14'($urandom_range(64, 0)), 8'($urandom_range(255, 0)), 1'b1);
        default: set_config(14'h3FFF, 8'($urandom_range(255, 0)), 1'b0);
      endcase
      calm = (phase == 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // stall the receiver while descriptors keep coming, so the input backs up
        if (phase == 1 && i == 20)
          hold_req = LONG_HOLD;
        send_descriptor(random_desc());
      end
      drain();
      calm = 1'b0;
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
